// File: design/mpdd_pkg.sv
// Package for the minimum pairwise disc distance block.
// Holds field widths, default sizes and the queue status type.
// Used by every module under design/; depends on nothing else.
package mpdd_pkg;

    // Field and datapath widths
    localparam int COORD_W = 32;                 // signed Q16.16 coordinate
    localparam int DIFF_W  = COORD_W + 1;        // exact signed difference
    localparam int PROD_W  = 2 * COORD_W;        // square of the low magnitude bits
    localparam int SQ_W    = 2 * DIFF_W;         // sum of two squares, unsigned
    localparam int ROOT_W  = DIFF_W;             // unsigned Q17.16 distance

    // Sizes
    localparam int MAX_CENTERS       = 3;
    localparam int DEF_CENTERS       = 3;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Status of the queue between the front and the back
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// File: design/mpdd_queue.sv
// Short first-in first-out queue of flip-flops between the front and the back.
// Depth must be a power of two of at least two; depends on mpdd_pkg.
module mpdd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mpdd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rd_data,
    output mpdd_pkg::q_status_t   status
);
    import mpdd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   wr_ptr_next;
    logic [PTR_W:0]   rd_ptr_reg;
    logic [PTR_W:0]   rd_ptr_next;
    logic             do_push;
    logic             do_pop;

    // The extra pointer bit tells a full queue from an empty one.
    always_comb
    begin
        status.empty = (wr_ptr_reg == rd_ptr_reg);
        status.full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                       (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        wr_ptr_next  = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    assign rd_data = mem_reg[rd_ptr_reg[PTR_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= wr_data;
        end
    end

endmodule

// File: design/mpdd_front.sv
// Front part: takes in one item, holds it and forms every A-to-B difference.
// Hands the packed differences to the queue; depends on mpdd_pkg.
module mpdd_front #(
    parameter int CENTERS = mpdd_pkg::DEF_CENTERS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic signed [mpdd_pkg::COORD_W-1:0]        a_x [0:mpdd_pkg::MAX_CENTERS-1],
    input  logic signed [mpdd_pkg::COORD_W-1:0]        a_y [0:mpdd_pkg::MAX_CENTERS-1],
    input  logic signed [mpdd_pkg::COORD_W-1:0]        b_x [0:mpdd_pkg::MAX_CENTERS-1],
    input  logic signed [mpdd_pkg::COORD_W-1:0]        b_y [0:mpdd_pkg::MAX_CENTERS-1],
    input  mpdd_pkg::q_status_t                        q_status,
    output logic                                       q_push,
    output logic [CENTERS*CENTERS*2*mpdd_pkg::DIFF_W-1:0] q_data
);
    import mpdd_pkg::*;

    logic                      vld_reg;
    logic                      vld_next;
    logic                      take;
    logic signed [COORD_W-1:0] ax_reg [0:CENTERS-1];
    logic signed [COORD_W-1:0] ay_reg [0:CENTERS-1];
    logic signed [COORD_W-1:0] bx_reg [0:CENTERS-1];
    logic signed [COORD_W-1:0] by_reg [0:CENTERS-1];

    // The holding register empties into the queue whenever there is room.
    always_comb
    begin
        q_push   = vld_reg && !q_status.full;
        in_ready = !vld_reg || !q_status.full;
        take     = in_valid && in_ready;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (q_push)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    for (genvar c = 0; c < CENTERS; c++)
    begin : g_hold
        always_ff @(posedge clk)
        begin
            if (take)
            begin
                ax_reg[c] <= a_x[c];
                ay_reg[c] <= a_y[c];
                bx_reg[c] <= b_x[c];
                by_reg[c] <= b_y[c];
            end
        end
    end

    // Pair i*CENTERS+j holds its x difference in the lower slot, y above it.
    for (genvar i = 0; i < CENTERS; i++)
    begin : g_a
        for (genvar j = 0; j < CENTERS; j++)
        begin : g_b
            localparam int P = i * CENTERS + j;
            assign q_data[(2*P)*DIFF_W +: DIFF_W] =
                {ax_reg[i][COORD_W-1], ax_reg[i]} - {bx_reg[j][COORD_W-1], bx_reg[j]};
            assign q_data[(2*P+1)*DIFF_W +: DIFF_W] =
                {ay_reg[i][COORD_W-1], ay_reg[i]} - {by_reg[j][COORD_W-1], by_reg[j]};
        end
    end

endmodule

// File: design/mpdd_back.sv
// Back part: magnitudes, squares, sums and a registered minimum tree.
// Pulls from the queue while the pipeline advances; depends on mpdd_pkg.
module mpdd_back #(
    parameter int CENTERS = mpdd_pkg::DEF_CENTERS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  mpdd_pkg::q_status_t                           q_status,
    input  logic [CENTERS*CENTERS*2*mpdd_pkg::DIFF_W-1:0] q_data,
    output logic                                          q_pop,
    output logic                                          min_vld,
    output logic [mpdd_pkg::SQ_W-1:0]                     min_sq
);
    import mpdd_pkg::*;

    localparam int PAIRS  = CENTERS * CENTERS;
    localparam int LANES  = 2 * PAIRS;
    localparam int LEVELS = $clog2(PAIRS);

    logic              abs_vld_reg;
    logic              mul_vld_reg;
    logic              tree_vld_reg [0:LEVELS];
    logic [DIFF_W-1:0] abs_reg  [0:LANES-1];
    logic [DIFF_W-1:0] abs_next [0:LANES-1];
    logic [PROD_W-1:0] ll_reg   [0:LANES-1];
    logic [PROD_W-1:0] ll_next  [0:LANES-1];
    logic              hi_reg   [0:LANES-1];
    logic [SQ_W-1:0]   tree_reg  [0:LEVELS][0:PAIRS-1];
    logic [SQ_W-1:0]   tree_next [0:LEVELS][0:PAIRS-1];

    assign q_pop = advance && !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            abs_vld_reg <= !q_status.empty;
            mul_vld_reg <= abs_vld_reg;
        end
    end

    for (genvar n = 0; n < LANES; n++)
    begin : g_lane
        logic [DIFF_W-1:0] d;
        assign d = q_data[n*DIFF_W +: DIFF_W];
        assign abs_next[n] = d[DIFF_W-1] ? (~d + 1'b1) : d;
        // A magnitude never exceeds 2^32, so when its top bit is set the
        // lower bits are zero and the square is just that top bit moved up.
        assign ll_next[n] = abs_reg[n][COORD_W-1:0] * abs_reg[n][COORD_W-1:0];

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                abs_reg[n] <= abs_next[n];
                ll_reg[n]  <= ll_next[n];
                hi_reg[n]  <= abs_reg[n][DIFF_W-1];
            end
        end
    end

    for (genvar p = 0; p < PAIRS; p++)
    begin : g_sum
        assign tree_next[0][p] = {1'b0, hi_reg[2*p],   ll_reg[2*p]}
                               + {1'b0, hi_reg[2*p+1], ll_reg[2*p+1]};
    end

    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_level
        localparam int N_PREV = (PAIRS + (1 << (l - 1)) - 1) >> (l - 1);
        localparam int N_CUR  = (PAIRS + (1 << l) - 1) >> l;
        for (genvar k = 0; k < PAIRS; k++)
        begin : g_node
            if ((k < N_CUR) && (2 * k + 1 < N_PREV))
            begin : g_cmp
                assign tree_next[l][k] = (tree_reg[l-1][2*k+1] < tree_reg[l-1][2*k])
                                       ? tree_reg[l-1][2*k+1] : tree_reg[l-1][2*k];
            end
            else if (k < N_CUR)
            begin : g_pass
                assign tree_next[l][k] = tree_reg[l-1][2*k];
            end
            else
            begin : g_unused
                assign tree_next[l][k] = '0;
            end
        end
    end

    for (genvar l = 0; l <= LEVELS; l++)
    begin : g_tree_regs
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tree_vld_reg[l] <= 1'b0;
            end
            else if (advance)
            begin
                tree_vld_reg[l] <= (l == 0) ? mul_vld_reg : tree_vld_reg[(l == 0) ? 0 : l-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                tree_reg[l] <= tree_next[l];
            end
        end
    end

    assign min_vld = tree_vld_reg[LEVELS];
    assign min_sq  = tree_reg[LEVELS][0];

endmodule

// File: design/mpdd_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor rounding.
// The last stage doubles as the output register; depends on mpdd_pkg.
module mpdd_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        in_vld,
    input  logic [mpdd_pkg::SQ_W-1:0]   in_sq,
    output logic                        out_vld,
    output logic [mpdd_pkg::ROOT_W-1:0] out_root
);
    import mpdd_pkg::*;

    logic              vld_reg [0:ROOT_W-1];
    logic [ROOT_W-1:0] res_reg [0:ROOT_W-1];
    logic [SQ_W-1:0]   rem_reg [0:ROOT_W-2];

    // Stage k settles bit b = ROOT_W-1-k. The remainder is the value minus the
    // square of the partial root; setting bit b costs (res << (b+1)) + 4^b.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic              vld_in;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] res_in;
        logic [SQ_W-1:0]   trial;
        logic              fits;
        logic [SQ_W-1:0]   rem_next;
        logic [ROOT_W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign vld_in = in_vld;
            assign rem_in = in_sq;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial    = (SQ_W'(res_in) << (B + 1)) | (SQ_W'(1) << (2 * B));
        assign fits     = (trial <= rem_in);
        assign rem_next = fits ? (rem_in - trial) : rem_in;
        assign res_next = fits ? (res_in | (ROOT_W'(1) << B)) : res_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                res_reg[k] <= res_next;
            end
        end

        if (k < ROOT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign out_root = res_reg[ROOT_W-1];

endmodule

// File: design/min_pairwise_disc_distance_top.sv
// Top level of the minimum pairwise disc distance block.
// Instantiates mpdd_front, mpdd_queue, mpdd_back and mpdd_isqrt; uses mpdd_pkg.
//
// Usage
// The input channel (in_valid / in_ready) carries one transfer per item: three
// disc centres of body A and three of body B, signed Q16.16. The output channel
// (out_valid / out_ready) returns one transfer per item, min_distance, the floor
// of the smallest centre-to-centre distance as unsigned Q17.16.
// Throughput is one item per clock cycle while the receiver does not stall.
// With three centres per body, an item passes in order through the front holding
// register, the queue, the magnitude, square and sum registers, the registered
// levels of the minimum tree over nine pairs, and the root, whose 33 stages each
// settle one result bit, the last being the output register.
// The front accepts items while the queue between front and back has room, so
// it keeps taking items while a finished result waits. The back pipeline,
// ending in the output register, advances whenever that register is empty or
// being read; when the receiver stalls the back holds, the queue fills and
// in_ready then drops.
// Reset clears every valid flag and the queue pointers; nothing else is kept.
module min_pairwise_disc_distance_top #(
    parameter int CENTERS_PER_BODY = mpdd_pkg::DEF_CENTERS,
    parameter int QUEUE_DEPTH      = mpdd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  a_x0,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  a_y0,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  a_x1,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  a_y1,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  a_x2,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  a_y2,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  b_x0,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  b_y0,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  b_x1,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  b_y1,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  b_x2,
    input  logic signed [mpdd_pkg::COORD_W-1:0]  b_y2,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mpdd_pkg::ROOT_W-1:0]          min_distance
);
    import mpdd_pkg::*;

    localparam int Q_W = CENTERS_PER_BODY * CENTERS_PER_BODY * 2 * DIFF_W;

    logic signed [COORD_W-1:0] a_x [0:MAX_CENTERS-1];
    logic signed [COORD_W-1:0] a_y [0:MAX_CENTERS-1];
    logic signed [COORD_W-1:0] b_x [0:MAX_CENTERS-1];
    logic signed [COORD_W-1:0] b_y [0:MAX_CENTERS-1];

    q_status_t       q_status;
    logic            q_push;
    logic            q_pop;
    logic [Q_W-1:0]  q_wr_data;
    logic [Q_W-1:0]  q_rd_data;
    logic            advance;
    logic            min_vld;
    logic [SQ_W-1:0] min_sq;

    assign a_x = '{a_x0, a_x1, a_x2};
    assign a_y = '{a_y0, a_y1, a_y2};
    assign b_x = '{b_x0, b_x1, b_x2};
    assign b_y = '{b_y0, b_y1, b_y2};

    // The whole back moves on together; the root's last stage is the output
    // register, so an empty or departing result lets every stage step.
    assign advance = !out_valid || out_ready;

    mpdd_front #(
        .CENTERS (CENTERS_PER_BODY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .a_x      (a_x),
        .a_y      (a_y),
        .b_x      (b_x),
        .b_y      (b_y),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    mpdd_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    mpdd_back #(
        .CENTERS (CENTERS_PER_BODY)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .q_status (q_status),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .min_vld  (min_vld),
        .min_sq   (min_sq)
    );

    mpdd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (min_vld),
        .in_sq    (min_sq),
        .out_vld  (out_valid),
        .out_root (min_distance)
    );

endmodule

// File: dv/mpdd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for min_pairwise_disc_distance_top: predicts the nearest disc-centre distance
// of every input transfer and compares each output transfer with it, in order.
// Depends on mpdd_pkg for the field widths.
module mpdd_checker #(
    parameter int CENTRES = mpdd_pkg::DEF_CENTERS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [11:0][mpdd_pkg::COORD_W-1:0]    coords,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [mpdd_pkg::ROOT_W-1:0]           min_distance,
    output int                                    errors,
    output int                                    pending,
    output int                                    items_in,
    output int                                    results_out
);
    import mpdd_pkg::*;

    localparam int B_BASE      = 6;
    localparam int PRINT_LIMIT = 30;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [ROOT_W-1:0]         dist_t;
    typedef logic [11:0][COORD_W-1:0]  body_set_t;

    typedef struct {
        int    seq;
        dist_t want;
    } dist_entry_t;

    dist_entry_t dist_due[$];

    // Exact squared distance between two centres; differences are taken in 33 bits.
    function automatic sq_t centre_gap_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
        dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
        dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
        if (dx[DIFF_W-1])
            dx = -dx;
        if (dy[DIFF_W-1])
            dy = -dy;
        return sq_t'(dx) * sq_t'(dx) + sq_t'(dy) * sq_t'(dy);
    endfunction

    // Floor of the square root, one result bit at a time from the top.
    function automatic dist_t floor_sqrt(sq_t v);
        dist_t root;
        dist_t cand;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            cand = root | (dist_t'(1) << b);
            if (sq_t'(cand) * sq_t'(cand) <= v)
                root = cand;
        end
        return root;
    endfunction

    function automatic dist_t nearest_centre_distance(body_set_t s);
        sq_t best;
        sq_t d;
        best = '0;
        for (int i = 0; i < CENTRES; i++)
        begin
            for (int j = 0; j < CENTRES; j++)
            begin
                d = centre_gap_sq(s[2*i], s[2*i+1], s[B_BASE+2*j], s[B_BASE+2*j+1]);
                if ((i == 0 && j == 0) || d < best)
                    best = d;
            end
        end
        return floor_sqrt(best);
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk)
    begin
        dist_entry_t head;
        dist_entry_t fresh;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (dist_due.size() == 0)
                    report_mismatch($sformatf("result %0h with no item outstanding",
                                              min_distance));
                else
                begin
                    head = dist_due.pop_front();
                    if (min_distance !== head.want)
                        report_mismatch($sformatf("item %0d: min_distance %0h, expected %0h",
                                                  head.seq, min_distance, head.want));
                end
                results_out++;
            end
            if (in_valid && in_ready)
            begin
                fresh.seq  = items_in;
                fresh.want = nearest_centre_distance(coords);
                dist_due.insert(dist_due.size(), fresh);
                items_in++;
            end
            pending = dist_due.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for min_pairwise_disc_distance_top: drives the item channel, paces the
// result channel and gives the verdict. Depends on mpdd_pkg and mpdd_checker.
module tb_top;
    import mpdd_pkg::*;

    localparam int B_BASE           = 6;
    localparam int RANDOM_PER_PHASE = 543;
    // No transfer for this many cycles means the block has hung. A correct run never goes
    // longer than an item's trip through the pipeline plus a short stall streak without one.
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 60;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic [11:0][COORD_W-1:0]  body_set_t;

    localparam coord_t C_MAX = 32'h7FFF_FFFF;
    localparam coord_t C_MIN = 32'h8000_0000;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    body_set_t           coords    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ROOT_W-1:0]   min_distance;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int errors;
    int pending;
    int items_in;
    int results_out;

    // The payload is held as twelve words: A centres 0..2 as (x, y), then B centres.
    min_pairwise_disc_distance_top #(
        .CENTERS_PER_BODY (DEF_CENTERS),
        .QUEUE_DEPTH      (DEF_QUEUE_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .a_x0         (coords[0]),
        .a_y0         (coords[1]),
        .a_x1         (coords[2]),
        .a_y1         (coords[3]),
        .a_x2         (coords[4]),
        .a_y2         (coords[5]),
        .b_x0         (coords[6]),
        .b_y0         (coords[7]),
        .b_x1         (coords[8]),
        .b_y1         (coords[9]),
        .b_x2         (coords[10]),
        .b_y2         (coords[11]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .min_distance (min_distance)
    );

    // The scoreboard watches both channels beside the block and owns all the result checking.
    mpdd_checker #(
        .CENTRES (DEF_CENTERS)
    ) score (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coords       (coords),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .min_distance (min_distance),
        .errors       (errors),
        .pending      (pending),
        .items_in     (items_in),
        .results_out  (results_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver decides afresh on every edge whether to take a result, so its stalls
    // land on every stage of the pipeline and on the queue filling and draining.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending);
                $display("min_pairwise_disc_distance_top regression: fail");
                $finish;
            end
        end
    end

    // Every A centre at one point and every B centre at another.
    function automatic body_set_t uniform_bodies(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        body_set_t s;
        for (int k = 0; k < 3; k++)
        begin
            s[2*k]            = ax;
            s[2*k+1]          = ay;
            s[B_BASE+2*k]     = bx;
            s[B_BASE+2*k+1]   = by;
        end
        return s;
    endfunction

    // A mix of shapes: full-range words, tight clusters of varying spread (so the
    // minimum is a close call among the nine pairs), extreme words, and sets where one
    // B centre sits almost on top of one A centre.
    function automatic body_set_t random_bodies();
        body_set_t   s;
        coord_t      base_x;
        coord_t      base_y;
        int unsigned mode;
        int unsigned spread;
        int unsigned i;
        int unsigned j;
        mode   = $urandom_range(99);
        base_x = $urandom;
        base_y = $urandom;
        spread = $urandom_range(31);
        for (int k = 0; k < 12; k++)
        begin
            if (mode < 30 || mode >= 85)
                s[k] = $urandom;
            else if (mode < 70)
                s[k] = ((k % 2) ? base_y : base_x) +
                       coord_t'($signed($urandom) >>> (31 - spread));
            else
            begin
                case ($urandom_range(5))
                    0:       s[k] = C_MAX;
                    1:       s[k] = C_MIN;
                    2:       s[k] = '0;
                    3:       s[k] = '1;
                    4:       s[k] = coord_t'(1);
                    default: s[k] = $urandom;
                endcase
            end
        end
        if (mode >= 85)
        begin
            i = $urandom_range(2);
            j = $urandom_range(2);
            s[B_BASE+2*j]   = s[2*i]   + coord_t'($urandom_range(16)) - coord_t'(8);
            s[B_BASE+2*j+1] = s[2*i+1] + coord_t'($urandom_range(16)) - coord_t'(8);
        end
        return s;
    endfunction

    // One item transfer, with random idle cycles ahead of it. Valid is only lowered when
    // an idle cycle is taken, so back-to-back items keep it high without a glitch.
    task automatic send_bodies(input body_set_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coords   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        body_set_t s;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First phase: the sender idles now and then, the receiver stalls most cycles.
        send_idle_pct  = 22;
        recv_stall_pct <= 67;

        // Directed items: coincident bodies, the widest separations in both directions,
        // pure x and pure y offsets, exact and inexact roots, and alternating bit patterns.
        send_bodies(uniform_bodies('0, '0, '0, '0));
        send_bodies(uniform_bodies(C_MAX, C_MAX, C_MIN, C_MIN));
        send_bodies(uniform_bodies(C_MIN, C_MIN, C_MAX, C_MAX));
        send_bodies(uniform_bodies(C_MAX, C_MIN, C_MAX, C_MIN));
        send_bodies(uniform_bodies(C_MAX, '0, C_MIN, '0));
        send_bodies(uniform_bodies('0, C_MIN, '0, C_MAX));
        send_bodies(uniform_bodies(coord_t'(3), coord_t'(4), '0, '0));
        send_bodies(uniform_bodies(32'h0003_0000, 32'h0004_0000, '0, '0));
        send_bodies(uniform_bodies(coord_t'(2), coord_t'(4), '0, '0));
        send_bodies(uniform_bodies(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA));
        send_bodies(uniform_bodies('1, '1, coord_t'(1), coord_t'(1)));

        // The nearest pair placed at each of the nine (A, B) combinations in turn; all
        // other pairs are far apart.
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s[2*k]          = coord_t'(k) << 28;
                    s[2*k+1]        = 32'h2000_0000;
                    s[B_BASE+2*k]   = C_MIN + (coord_t'(k) << 27);
                    s[B_BASE+2*k+1] = C_MIN;
                end
                s[B_BASE+2*j]   = s[2*i] + coord_t'(5);
                s[B_BASE+2*j+1] = s[2*i+1] - coord_t'(7);
                send_bodies(s);
            end
        end

        // A tie: all nine pairs are exactly the same distance apart.
        s = uniform_bodies('0, '0, coord_t'(3), coord_t'(4));
        s[B_BASE+2]   = coord_t'(-3);
        s[B_BASE+3]   = coord_t'(4);
        s[B_BASE+4]   = coord_t'(4);
        s[B_BASE+5]   = coord_t'(-3);
        send_bodies(s);

        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_bodies(random_bodies());

        // Second phase: the pressure is reversed.
        send_idle_pct  = 67;
        recv_stall_pct <= 22;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_bodies(random_bodies());

        // Third phase: full rate on both sides.
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_bodies(random_bodies());
        in_valid <= 1'b0;

        // Wait for the pipeline to empty; the watchdog bounds this wait.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d item transfers and %0d result transfers under three idling",
                 items_in, results_out);
        $display("mixes, with extreme, clustered, tied and near-pair centre sets.");
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("min_pairwise_disc_distance_top regression: pass");
        else
            $display("min_pairwise_disc_distance_top regression: fail");
        $finish;
    end

endmodule
